/* src/esc_pkg.sv */
package esc_pkg;

   localparam int DivBits = 32;

   localparam logic [31:0] TempOffsetP = 32'd64000;
   localparam logic [31:0] PressBase   = 32'd1048576;
   localparam logic [31:0] PressScale  = 32'd3125;
   localparam logic [31:0] HumOffset   = 32'd76800;
   localparam logic [31:0] HumBias     = 32'd2097152;
   localparam logic [31:0] HumMax      = 32'd419430400;

   localparam logic [2:0] CsrTempTrim   = 3'd0;
   localparam logic [2:0] CsrPressTrimA = 3'd1;
   localparam logic [2:0] CsrPressTrimB = 3'd2;
   localparam logic [2:0] CsrPressTrimC = 3'd3;
   localparam logic [2:0] CsrHumTrim    = 3'd4;

   // trim coefficients, each extended to the 32-bit working width
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } trim_type;

   // front result queued for the back end
   typedef struct packed {
      logic [17:0] temp;
      logic [31:0] tfine;
      logic [19:0] ap;
      logic [15:0] ah;
   } fb_item_type;

   // values that ride along the divider
   typedef struct packed {
      logic [17:0] temp;
      logic [31:0] hx;
      logic [31:0] hsq;
      logic        zero;
      logic        big;
   } div_side_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] s;
      s = $signed(x);
      return 32'(s >>> n);
   endfunction

endpackage

/* src/esc_fifo.sv */
module esc_fifo
   import esc_pkg::*;
#(
   parameter int Depth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fb_item_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output fb_item_type pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   fb_item_type         mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [CntW-1:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* src/esc_front.sv */
module esc_front
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  trim_type    trim,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [19:0] in_at,
   input  logic [19:0] in_ap,
   input  logic [15:0] in_ah,
   output logic        out_valid,
   input  logic        out_full,
   output fb_item_type out_item
);

   logic        adv;
   logic [3:0]  vld_ff;

   logic [31:0] f1_m1_ff, f1_dd_ff;
   logic [19:0] f1_ap_ff, f2_ap_ff, f3_ap_ff;
   logic [15:0] f1_ah_ff, f2_ah_ff, f3_ah_ff;
   logic [31:0] f2_v1_ff, f2_m2_ff;
   logic [31:0] f3_tfine_ff;
   fb_item_type f4_item_ff;

   logic [31:0] at32, dif, t5;

   assign adv       = !vld_ff[3] || !out_full;
   assign in_ready  = adv;
   assign out_valid = vld_ff[3];
   assign out_item  = f4_item_ff;

   assign at32 = {12'd0, in_at};
   assign dif  = (at32 >> 4) - trim.t1;
   assign t5   = (f3_tfine_ff << 2) + f3_tfine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_m1_ff    <= ((at32 >> 3) - (trim.t1 << 1)) * trim.t2;
         f1_dd_ff    <= dif * dif;
         f1_ap_ff    <= in_ap;
         f1_ah_ff    <= in_ah;
         f2_v1_ff    <= asr(f1_m1_ff, 11);
         f2_m2_ff    <= asr(f1_dd_ff, 12) * trim.t3;
         f2_ap_ff    <= f1_ap_ff;
         f2_ah_ff    <= f1_ah_ff;
         f3_tfine_ff <= f2_v1_ff + asr(f2_m2_ff, 14);
         f3_ap_ff    <= f2_ap_ff;
         f3_ah_ff    <= f2_ah_ff;
         f4_item_ff.temp  <= 18'(asr(t5 + 32'd128, 8));
         f4_item_ff.tfine <= f3_tfine_ff;
         f4_item_ff.ap    <= f3_ap_ff;
         f4_item_ff.ah    <= f3_ah_ff;
      end
   end

endmodule

/* src/esc_div.sv */
module esc_div
   import esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  logic [31:0]  in_num,
   input  logic [31:0]  in_den,
   input  div_side_type in_side,
   output logic         out_valid,
   output logic [31:0]  out_quo,
   output div_side_type out_side
);

   logic [DivBits-1:0] vld_ff;
   logic [31:0]        rem_ff  [DivBits];
   logic [31:0]        n_ff    [DivBits];
   logic [31:0]        d_ff    [DivBits];
   div_side_type       side_ff [DivBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DivBits-2:0], in_valid};
      end
   end

   // one quotient bit per stage, restoring form
   for (genvar i = 0; i < DivBits; i++) begin : g_stage
      logic [31:0] rem_prev, n_prev, d_prev;
      div_side_type side_prev;
      logic [32:0] r_sh, r_sub;
      logic        ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign n_prev    = in_num;
         assign d_prev    = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign n_prev    = n_ff[i-1];
         assign d_prev    = d_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign r_sh  = {rem_prev, n_prev[31]};
      assign r_sub = r_sh - {1'b0, d_prev};
      assign ge    = (r_sh >= {1'b0, d_prev});

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= ge ? r_sub[31:0] : r_sh[31:0];
            n_ff[i]    <= {n_prev[30:0], ge};
            d_ff[i]    <= d_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[DivBits-1];
   assign out_quo   = n_ff[DivBits-1];
   assign out_side  = side_ff[DivBits-1];

endmodule

/* src/esc_back.sv */
module esc_back
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  trim_type    trim,
   input  logic        in_valid,
   output logic        in_ready,
   input  fb_item_type in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [17:0] out_temp,
   output logic [31:0] out_pres,
   output logic [13:0] out_hum
);

   logic        adv;
   logic [5:0]  vld_ff;
   logic [2:0]  pv_ff;

   // s1
   logic [31:0] s1_v1_ff, s1_qq_ff, s1_hx_ff, s1_mh5_ff, s1_mh6_ff, s1_mh3_ff;
   logic [19:0] s1_ap_ff;
   logic [15:0] s1_ah_ff;
   logic [17:0] s1_temp_ff;
   // s2
   logic [31:0] s2_ma_ff, s2_mb_ff, s2_mc_ff, s2_md_ff, s2_ha_ff, s2_hmb_ff;
   logic [19:0] s2_ap_ff;
   logic [17:0] s2_temp_ff;
   // s3
   logic [31:0] s3_v2_ff, s3_s_ff, s3_hm2_ff, s3_ha_ff;
   logic [19:0] s3_ap_ff;
   logic [17:0] s3_temp_ff;
   // s4
   logic [31:0] s4_me_ff, s4_num0_ff, s4_hb_ff, s4_ha_ff;
   logic [17:0] s4_temp_ff;
   // s5
   logic [31:0] s5_den_ff, s5_num_ff, s5_hx_ff;
   logic [17:0] s5_temp_ff;
   // s6: divider input
   logic [31:0] s6_num_ff, s6_den_ff;
   div_side_type s6_side_ff;
   // after divider
   logic        dv_valid;
   logic [31:0] dv_quo;
   div_side_type dv_side;
   logic [31:0] p1_pres_ff, p1_mm_ff, p1_mf_ff, p1_hm1_ff, p1_hx_ff;
   logic [17:0] p1_temp_ff;
   logic        p1_zero_ff;
   logic [31:0] p2_pres_ff, p2_mf_ff, p2_mg_ff;
   logic [16:0] p2_hw_ff;
   logic [17:0] p2_temp_ff;
   logic        p2_zero_ff;
   logic [17:0] p3_temp_ff;
   logic [31:0] p3_pres_ff;
   logic [13:0] p3_hum_ff;

   logic [31:0] c_v1, c_q, c_hx, c_ah32, c_ap32, c_hs, c_pres, c_s3, c_hx3, c_hcl;
   logic [31:0] c_hw100, c_corr;

   assign adv       = !pv_ff[2] || out_ready;
   assign in_ready  = adv;
   assign out_valid = pv_ff[2];
   assign out_temp  = p3_temp_ff;
   assign out_pres  = p3_pres_ff;
   assign out_hum   = p3_hum_ff;

   assign c_v1   = asr(in_item.tfine, 1) - TempOffsetP;
   assign c_q    = asr(c_v1, 2);
   assign c_hx   = in_item.tfine - HumOffset;
   assign c_ah32 = {16'd0, s1_ah_ff};
   assign c_ap32 = {12'd0, s3_ap_ff};
   assign c_hs   = asr(s5_hx_ff, 15);
   assign c_pres = dv_side.big ? (dv_quo << 1) : dv_quo;
   assign c_s3   = c_pres >> 3;
   assign c_hx3  = p1_hx_ff - asr(p1_hm1_ff, 4);
   // clamp the humidity accumulator to its legal range
   assign c_hcl  = c_hx3[31] ? 32'd0
                 : ($signed(c_hx3) > $signed(HumMax)) ? HumMax : c_hx3;
   assign c_hw100 = {15'd0, p2_hw_ff} * 32'd100;
   assign c_corr  = asr(asr(p2_mg_ff, 12) + asr(p2_mf_ff, 13) + trim.p7, 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         pv_ff  <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_valid};
         pv_ff  <= {pv_ff[1:0], dv_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_v1_ff   <= c_v1;
         s1_qq_ff   <= c_q * c_q;
         s1_hx_ff   <= c_hx;
         s1_mh5_ff  <= trim.h5 * c_hx;
         s1_mh6_ff  <= c_hx * trim.h6;
         s1_mh3_ff  <= c_hx * trim.h3;
         s1_ap_ff   <= in_item.ap;
         s1_ah_ff   <= in_item.ah;
         s1_temp_ff <= in_item.temp;

         s2_ma_ff   <= asr(s1_qq_ff, 11) * trim.p6;
         s2_mb_ff   <= s1_v1_ff * trim.p5;
         s2_mc_ff   <= trim.p3 * asr(s1_qq_ff, 13);
         s2_md_ff   <= trim.p2 * s1_v1_ff;
         s2_ha_ff   <= asr((c_ah32 << 14) - (trim.h4 << 20) - s1_mh5_ff + 32'd16384, 15);
         s2_hmb_ff  <= asr(s1_mh6_ff, 10) * (asr(s1_mh3_ff, 11) + 32'd32768);
         s2_ap_ff   <= s1_ap_ff;
         s2_temp_ff <= s1_temp_ff;

         s3_v2_ff   <= asr(s2_ma_ff + (s2_mb_ff << 1), 2) + (trim.p4 << 16);
         s3_s_ff    <= asr(asr(s2_mc_ff, 3) + asr(s2_md_ff, 1), 18);
         s3_hm2_ff  <= (asr(s2_hmb_ff, 10) + HumBias) * trim.h2;
         s3_ha_ff   <= s2_ha_ff;
         s3_ap_ff   <= s2_ap_ff;
         s3_temp_ff <= s2_temp_ff;

         s4_me_ff   <= (32'd32768 + s3_s_ff) * trim.p1;
         s4_num0_ff <= (PressBase - c_ap32) - asr(s3_v2_ff, 12);
         s4_hb_ff   <= asr(s3_hm2_ff + 32'd8192, 14);
         s4_ha_ff   <= s3_ha_ff;
         s4_temp_ff <= s3_temp_ff;

         s5_den_ff  <= asr(s4_me_ff, 15);
         s5_num_ff  <= s4_num0_ff * PressScale;
         s5_hx_ff   <= s4_ha_ff * s4_hb_ff;
         s5_temp_ff <= s4_temp_ff;

         // large dividend: divide first, double after
         s6_num_ff       <= s5_num_ff[31] ? s5_num_ff : (s5_num_ff << 1);
         s6_den_ff       <= s5_den_ff;
         s6_side_ff.big  <= s5_num_ff[31];
         s6_side_ff.zero <= (s5_den_ff == '0);
         s6_side_ff.hx   <= s5_hx_ff;
         s6_side_ff.hsq  <= c_hs * c_hs;
         s6_side_ff.temp <= s5_temp_ff;

         p1_pres_ff <= c_pres;
         p1_mm_ff   <= c_s3 * c_s3;
         p1_mf_ff   <= (c_pres >> 2) * trim.p8;
         p1_hm1_ff  <= asr(dv_side.hsq, 7) * trim.h1;
         p1_hx_ff   <= dv_side.hx;
         p1_temp_ff <= dv_side.temp;
         p1_zero_ff <= dv_side.zero;

         p2_mg_ff   <= trim.p9 * (p1_mm_ff >> 13);
         p2_mf_ff   <= p1_mf_ff;
         p2_pres_ff <= p1_pres_ff;
         p2_hw_ff   <= c_hcl[28:12];
         p2_temp_ff <= p1_temp_ff;
         p2_zero_ff <= p1_zero_ff;

         p3_temp_ff <= p2_temp_ff;
         p3_pres_ff <= p2_zero_ff ? 32'd0 : p2_pres_ff + c_corr;
         p3_hum_ff  <= c_hw100[23:10];
      end
   end

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[5]),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

endmodule

/* src/env_sensor_compensation.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  raw temperature, pressure, humidity
// rsp      out        rsp_valid/rsp_ready  temperature, pressure, humidity
// csr      in         csr_valid/csr_ready  register index, 64-bit write data
//
// One sample triple accepted per cycle while req_ready is high; each passes the front
// pipeline, the queue and a back end built around the 32-stage pipelined divider.
// Reset clears the trim registers, the valid bits and the queue pointers.
// A stall on rsp holds the back end; the queue lets the front end keep taking
// transactions until it fills.
module env_sensor_compensation
   import esc_pkg::*;
#(
   parameter int FifoDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [17:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pa,
   output logic [13:0] rsp_humidity_centi,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [47:0] temp_trim_ff;
   logic [63:0] press_trim_a_ff;
   logic [63:0] press_trim_b_ff;
   logic [15:0] press_trim_c_ff;
   logic [63:0] hum_trim_ff;
   trim_type    trim;

   logic        f_valid, q_full, q_empty, b_ready;
   fb_item_type f_item, q_item;
   logic [17:0] b_temp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff    <= '0;
         press_trim_a_ff <= '0;
         press_trim_b_ff <= '0;
         press_trim_c_ff <= '0;
         hum_trim_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrTempTrim:   temp_trim_ff    <= csr_data[47:0];
            CsrPressTrimA: press_trim_a_ff <= csr_data;
            CsrPressTrimB: press_trim_b_ff <= csr_data;
            CsrPressTrimC: press_trim_c_ff <= csr_data[15:0];
            CsrHumTrim:    hum_trim_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      trim.t1 = {16'd0, temp_trim_ff[15:0]};
      trim.t2 = 32'($signed(temp_trim_ff[31:16]));
      trim.t3 = 32'($signed(temp_trim_ff[47:32]));
      trim.p1 = {16'd0, press_trim_a_ff[15:0]};
      trim.p2 = 32'($signed(press_trim_a_ff[31:16]));
      trim.p3 = 32'($signed(press_trim_a_ff[47:32]));
      trim.p4 = 32'($signed(press_trim_a_ff[63:48]));
      trim.p5 = 32'($signed(press_trim_b_ff[15:0]));
      trim.p6 = 32'($signed(press_trim_b_ff[31:16]));
      trim.p7 = 32'($signed(press_trim_b_ff[47:32]));
      trim.p8 = 32'($signed(press_trim_b_ff[63:48]));
      trim.p9 = 32'($signed(press_trim_c_ff));
      trim.h1 = {24'd0, hum_trim_ff[7:0]};
      trim.h2 = 32'($signed(hum_trim_ff[23:8]));
      trim.h3 = {24'd0, hum_trim_ff[31:24]};
      trim.h4 = 32'($signed(hum_trim_ff[43:32]));
      trim.h5 = 32'($signed(hum_trim_ff[55:44]));
      trim.h6 = 32'($signed(hum_trim_ff[63:56]));
   end

   esc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .trim      (trim),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_at     (req_raw_temperature),
      .in_ap     (req_raw_pressure),
      .in_ah     (req_raw_humidity),
      .out_valid (f_valid),
      .out_full  (q_full),
      .out_item  (f_item)
   );

   esc_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_item),
      .full      (q_full),
      .pop       (b_ready),
      .empty     (q_empty),
      .pop_data  (q_item)
   );

   esc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .trim      (trim),
      .in_valid  (!q_empty),
      .in_ready  (b_ready),
      .in_item   (q_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_temp  (b_temp),
      .out_pres  (rsp_pressure_pa),
      .out_hum   (rsp_humidity_centi)
   );

   assign rsp_temperature_centi = $signed(b_temp);

endmodule
